[src/grme_pkg.sv]
// Package for the grid ring-mean embedding block.
// Transaction payload types, configuration indexes and reset values.
// No dependencies.
`default_nettype none
package grme_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_GRID_ROWS       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GRID_COLS       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_EMBED_DIM       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LAG_STEP        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INCLUDE_CURRENT = 3'd4;

  localparam logic [6:0] GRID_ROWS_RST       = 7'd64;
  localparam logic [6:0] GRID_COLS_RST       = 7'd64;
  localparam logic [3:0] EMBED_DIM_RST       = 4'd3;
  localparam logic [5:0] LAG_STEP_RST        = 6'd1;
  localparam logic       INCLUDE_CURRENT_RST = 1'b0;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam int unsigned SampleW = 16;

  typedef struct packed {
    logic               mode;
    logic [5:0]         cell_row;
    logic [5:0]         cell_col;
    logic signed [15:0] sample_value;
    logic               sample_valid;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         column_index;
    logic signed [15:0] mean_value;
    logic               mean_valid;
    logic               last_of_run;
  } out_item_t;

endpackage
`default_nettype wire

[src/grme_if.sv]
// Valid/ready channel interfaces for the grid ring-mean embedding block.
// Depends on grme_pkg.
`default_nettype none
interface grme_in_if import grme_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface grme_out_if import grme_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/grid_ring_mean_embedding.sv]
// Top level of the grid ring-mean embedding block: grid memory, ring walker,
// serial divider and result register. Depends on grme_pkg and grme_if.
//
//   channel | dir | payload                                         | handshake
//   in_i    | in  | mode, cell_row, cell_col, sample_value/valid    | valid/ready
//   out_o   | out | column_index, mean_value, mean_valid, last      | valid/ready
//   cfg     | in  | cfg_idx_i, cfg_data_i                           | cfg_we_i
//
// After reset a clearing pass writes all 2**(RW+CW) entries (4096 by default) before in_i is ready.
// A load writes the grid when it is accepted. Per query column: a setup state, a walk over each
// cell on the ring's top and bottom rows and over the two side cells of each row between them,
// a drain and a divide-load state, a divide of one quotient bit per cycle (skipped for an empty
// ring) and an output state. A query outside the grid goes from setup straight to output.
// One transaction is worked on at a time; a stalled result holds the block.
`default_nettype none
module grid_ring_mean_embedding import grme_pkg::*; #(
  parameter int unsigned ROWS_MAX  = 64,
  parameter int unsigned COLS_MAX  = 64,
  parameter int unsigned EMBED_MAX = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  grme_in_if.sink                  in_i,
  grme_out_if.source               out_o
);

  localparam int unsigned RW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int unsigned CW   = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int unsigned AW   = RW + CW;
  localparam int unsigned KW   = $clog2(EMBED_MAX + 1);
  localparam int unsigned LW   = KW + 6;
  localparam int unsigned DMAX = (ROWS_MAX > COLS_MAX) ? ROWS_MAX : COLS_MAX;
  localparam int unsigned GW   = $clog2(DMAX + (1 << LW)) + 2;
  localparam int unsigned NW   = $clog2(2 * ROWS_MAX + 2 * COLS_MAX + 1);
  localparam int unsigned SW   = SampleW + NW;
  localparam int unsigned DCW  = $clog2(SW + 1);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SETUP = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_DIVLD = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [6:0] rows_cfg_q, cols_cfg_q;
  logic [3:0] dim_cfg_q;
  logic [5:0] tau_q;
  logic       inc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= GRID_ROWS_RST;
      cols_cfg_q <= GRID_COLS_RST;
      dim_cfg_q  <= EMBED_DIM_RST;
      tau_q      <= LAG_STEP_RST;
      inc_q      <= INCLUDE_CURRENT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_ROWS:       rows_cfg_q <= cfg_data_i[6:0];
        CFG_GRID_COLS:       cols_cfg_q <= cfg_data_i[6:0];
        CFG_EMBED_DIM:       dim_cfg_q  <= cfg_data_i[3:0];
        CFG_LAG_STEP:        tau_q      <= cfg_data_i[5:0];
        CFG_INCLUDE_CURRENT: inc_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic signed [GW-1:0] rows_s, cols_s;
  logic [KW-1:0]        dim;

  always_comb begin
    if (rows_cfg_q == 7'd0)                 rows_s = GW'(1);
    else if (GW'(rows_cfg_q) > GW'(ROWS_MAX)) rows_s = GW'(ROWS_MAX);
    else                                    rows_s = GW'(rows_cfg_q);
    if (cols_cfg_q == 7'd0)                 cols_s = GW'(1);
    else if (GW'(cols_cfg_q) > GW'(COLS_MAX)) cols_s = GW'(COLS_MAX);
    else                                    cols_s = GW'(cols_cfg_q);
    if (dim_cfg_q == 4'd0)                  dim = KW'(1);
    else if (32'(dim_cfg_q) > EMBED_MAX)    dim = KW'(EMBED_MAX);
    else                                    dim = KW'(dim_cfg_q);
  end

  // input decode
  logic signed [GW-1:0] in_r, in_c;
  logic                 in_inside, in_fire;

  assign in_r      = GW'(in_i.data.cell_row);
  assign in_c      = GW'(in_i.data.cell_col);
  assign in_inside = (in_r < rows_s) && (in_c < cols_s);
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;

  // query context
  logic signed [GW-1:0] cr_q, cc_q, r_q, c_q;
  logic                 inside_q, side_q;
  logic [KW-1:0]        k_q;
  logic [LW-1:0]        lag_q, lag_new;
  logic [KW-1:0]        kmul;

  always_comb begin
    kmul = (tau_q == 6'd0 || inc_q) ? k_q : k_q + KW'(1);
    if (tau_q == 6'd0) lag_new = LW'(k_q);
    else               lag_new = LW'(kmul) * LW'(tau_q);
  end

  logic [LW-1:0]        lag_sel;
  logic signed [GW-1:0] lag_s, top, bot, lft, rgt, r0, r1, c0, c1;

  always_comb begin
    lag_sel = (state_q == S_SETUP) ? lag_new : lag_q;
    lag_s   = GW'(lag_sel);
    top = cr_q - lag_s;
    bot = cr_q + lag_s;
    lft = cc_q - lag_s;
    rgt = cc_q + lag_s;
    r0  = (top < 0) ? '0 : top;
    r1  = (bot > rows_s - GW'(1)) ? rows_s - GW'(1) : bot;
    c0  = (lft < 0) ? '0 : lft;
    c1  = (rgt > cols_s - GW'(1)) ? cols_s - GW'(1) : rgt;
  end

  // grid memory: {present, value}
  logic [SampleW:0] mem_q [2**AW];
  logic [SampleW:0] rd_q, wdata;
  logic [AW-1:0]    waddr, raddr, clr_q;
  logic             we, issue, pend_q;
  logic signed [GW-1:0] rd_col;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  logic edge_row;
  assign edge_row = (r_q == top) || (r_q == bot);

  always_comb begin
    if (edge_row)     rd_col = c_q;
    else if (!side_q) rd_col = lft;
    else              rd_col = rgt;
    raddr = {r_q[RW-1:0], rd_col[CW-1:0]};
    issue = 1'b0;
    if (state_q == S_WALK) begin
      if (edge_row)     issue = 1'b1;
      else if (!side_q) issue = (lft >= 0);
      else              issue = (rgt <= cols_s - GW'(1));
    end
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = '0;
    end else begin
      we    = in_fire && (in_i.data.mode == MODE_LOAD) && in_inside;
      waddr = {in_r[RW-1:0], in_c[CW-1:0]};
      wdata = {in_i.data.sample_valid, in_i.data.sample_value};
    end
  end

  // accumulation and divide
  logic signed [SW-1:0] sum_q;
  logic [NW-1:0]        cnt_q;
  logic [SW-1:0]        quo_q;
  logic [NW:0]          rem_q, shifted;
  logic [DCW-1:0]       dcnt_q;
  logic                 neg_q;
  out_item_t            res_q, res_d;
  logic [SampleW-1:0]   mag;

  assign shifted = {rem_q[NW-1:0], quo_q[SW-1]};
  assign mag     = quo_q[SampleW-1:0];

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    res_d.column_index = 3'(k_q);
    res_d.last_of_run  = (k_q == dim - KW'(1));
    unique case (state_q)
      S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
      S_IDLE:  if (in_fire && in_i.data.mode == MODE_QUERY) state_d = S_SETUP;
      S_SETUP: begin
        if (inside_q) state_d = S_WALK;
        else begin
          res_d.mean_value = '0;
          res_d.mean_valid = 1'b0;
          state_d = S_OUT;
        end
      end
      S_WALK: begin
        if ((edge_row ? (c_q == c1) : side_q) && r_q == r1) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_DIVLD;
      S_DIVLD: begin
        if (cnt_q == '0) begin
          res_d.mean_value = '0;
          res_d.mean_valid = 1'b0;
          state_d = S_OUT;
        end else state_d = S_DIV;
      end
      S_DIV: begin
        if (dcnt_q == '0) begin
          res_d.mean_value = neg_q ? -mag : mag;
          res_d.mean_valid = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) state_d = res_q.last_of_run ? S_IDLE : S_SETUP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (in_fire) k_q <= '0;
      else if (state_q == S_OUT && out_o.ready) k_q <= k_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_fire) begin
      cr_q     <= in_r;
      cc_q     <= in_c;
      inside_q <= in_inside;
    end
    if (state_q == S_SETUP) begin
      lag_q  <= lag_new;
      r_q    <= r0;
      c_q    <= c0;
      side_q <= 1'b0;
      sum_q  <= '0;
      cnt_q  <= '0;
    end else begin
      if (pend_q && rd_q[SampleW]) begin
        sum_q <= sum_q + SW'($signed(rd_q[SampleW-1:0]));
        cnt_q <= cnt_q + NW'(1);
      end
      if (state_q == S_WALK) begin
        if (edge_row ? (c_q == c1) : side_q) begin
          r_q    <= r_q + GW'(1);
          c_q    <= c0;
          side_q <= 1'b0;
        end else if (edge_row) c_q <= c_q + GW'(1);
        else side_q <= 1'b1;
      end
    end
    if (state_q == S_DIVLD) begin
      neg_q  <= sum_q[SW-1];
      quo_q  <= sum_q[SW-1] ? -sum_q : sum_q;
      rem_q  <= '0;
      dcnt_q <= DCW'(SW);
    end else if (state_q == S_DIV && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - DCW'(1);
      if (shifted >= {1'b0, cnt_q}) begin
        rem_q <= shifted - {1'b0, cnt_q};
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end

  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = res_q;

endmodule
`default_nettype wire

[src/grme_checker.sv]
// Port-level checks for the grid ring-mean embedding block, bound to the top.
// Depends on grme_pkg.
`default_nettype none
module grme_checker import grme_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input taken while result pending");

  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_data_i.last_of_run |=> !in_ready_i)
    else $error("query ended before last column");

  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.mean_valid |-> out_data_i.mean_value == '0)
    else $error("invalid mean not zero");

endmodule

bind grid_ring_mean_embedding grme_checker u_grme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
`default_nettype wire

[tb/grme_tb_if.sv]
// Testbench copy of nothing: the channel interfaces come from src/grme_if.sv.
// This file holds the checker's helper types. Depends on grme_pkg.
`timescale 1ns / 1ps
package grme_tb_pkg;
  import grme_pkg::*;

  typedef struct {
    logic [2:0]         column_index;
    logic signed [15:0] mean_value;
    logic               mean_valid;
    logic               last_of_run;
  } ring_mean_t;
endpackage

[tb/grme_checker.sv]
// Checker for the grid ring-mean embedding block: watches both channels and the
// config port, keeps its own grid and registers, and counts mismatches.
// Depends on grme_pkg, grme_tb_pkg and the channel interfaces.
`timescale 1ns / 1ps
module grme_tb_checker import grme_pkg::*; import grme_tb_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  grme_in_if                       in_i,
  grme_out_if                      out_i,
  output int                       errors_o,
  output int                       pending_o
);
  logic signed [15:0] grid_val [4096];
  logic               grid_ok  [4096];
  logic [6:0] rows_r, cols_r;
  logic [3:0] dim_r;
  logic [5:0] tau_r;
  logic       incl_r;
  ring_mean_t means_q [$];

  function automatic int clip(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic ring_mean_t ring_mean(int cr, int cc, int lag, int nr, int nc);
    ring_mean_t m;
    longint sum;
    longint cnt;
    int dr, dc;
    sum = 0;
    cnt = 0;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        dr = (r > cr) ? r - cr : cr - r;
        dc = (c > cc) ? c - cc : cc - c;
        if (((dr > dc) ? dr : dc) == lag && grid_ok[r*64+c]) begin
          sum += grid_val[r*64+c];
          cnt++;
        end
      end
    end
    m.mean_valid = cnt > 0;
    m.mean_value = cnt > 0 ? 16'(sum / cnt) : 16'sd0;
    return m;
  endfunction

  task automatic predict_query(in_item_t it);
    int nr, nc, nd, lag;
    ring_mean_t m;
    nr = clip(rows_r, 64);
    nc = clip(cols_r, 64);
    nd = clip(dim_r, 8);
    for (int k = 0; k < nd; k++) begin
      if (tau_r == 0) lag = k;
      else if (incl_r) lag = k * tau_r;
      else lag = (k + 1) * tau_r;
      if (it.cell_row < nr && it.cell_col < nc) begin
        m = ring_mean(it.cell_row, it.cell_col, lag, nr, nc);
      end else begin
        m.mean_valid = 1'b0;
        m.mean_value = '0;
      end
      m.column_index = 3'(k);
      m.last_of_run = (k == nd - 1);
      means_q.insert(means_q.size(), m);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ring_mean_t e;
    if (!rst_ni) begin
      rows_r = GRID_ROWS_RST;
      cols_r = GRID_COLS_RST;
      dim_r = EMBED_DIM_RST;
      tau_r = LAG_STEP_RST;
      incl_r = INCLUDE_CURRENT_RST;
      foreach (grid_ok[i]) grid_ok[i] = 1'b0;
      means_q.delete();
      errors_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (means_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_i.data);
          errors_o++;
        end else begin
          e = means_q.pop_front();
          if (out_i.data.column_index !== e.column_index ||
              out_i.data.mean_value !== e.mean_value ||
              out_i.data.mean_valid !== e.mean_valid ||
              out_i.data.last_of_run !== e.last_of_run) begin
            $display("%0t: mismatch expected col %0d mean %0d ok %0b last %0b, got %p",
                     $time, e.column_index, e.mean_value, e.mean_valid,
                     e.last_of_run, out_i.data);
            errors_o++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.data.mode == MODE_QUERY) predict_query(in_i.data);
        else if (in_i.data.cell_row < clip(rows_r, 64) &&
                 in_i.data.cell_col < clip(cols_r, 64)) begin
          grid_val[in_i.data.cell_row*64+in_i.data.cell_col] = in_i.data.sample_value;
          grid_ok[in_i.data.cell_row*64+in_i.data.cell_col] = in_i.data.sample_valid;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRID_ROWS:       rows_r = cfg_data_i;
          CFG_GRID_COLS:       cols_r = cfg_data_i;
          CFG_EMBED_DIM:       dim_r = cfg_data_i[3:0];
          CFG_LAG_STEP:        tau_r = cfg_data_i[5:0];
          CFG_INCLUDE_CURRENT: incl_r = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o = means_q.size();
  end
endmodule

[tb/grid_ring_mean_embedding_tb.sv]
// Top of the grid ring-mean embedding testbench: clock, reset, config phases,
// load/query stimulus and result back-pressure. Depends on grme_pkg, the
// channel interfaces, grme_tb_checker and the block.
`timescale 1ns / 1ps
module grid_ring_mean_embedding_tb;
  import grme_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  int errors, pending;
  longint cycles = 0;
  bit long_hold = 1'b0;
  logic [5:0] cur_rows = 6'd63, cur_cols = 6'd63;

  grme_in_if  in_ch ();
  grme_out_if out_ch ();

  always #6 clk_i = ~clk_i;

  grid_ring_mean_embedding dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  grme_tb_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_ch), .out_i(out_ch),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 10_000_000) begin
      $display("FAIL grid_ring_mean_embedding");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgDataW'(val);
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic send(logic md, int r, int c, int v, logic ok);
    in_item_t it;
    it.mode = md;
    it.cell_row = 6'(r);
    it.cell_col = 6'(c);
    it.sample_value = 16'(v);
    it.sample_valid = ok;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic configure(int r, int c, int d, int t, int inc);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(CFG_GRID_ROWS, r);
    write_reg(CFG_GRID_COLS, c);
    write_reg(CFG_EMBED_DIM, d);
    write_reg(CFG_LAG_STEP, t);
    write_reg(CFG_INCLUDE_CURRENT, inc);
    cfg_we_i <= 1'b0;
    cur_rows = 6'((r < 1) ? 0 : (r > 64 ? 63 : r - 1));
    cur_cols = 6'((c < 1) ? 0 : (c > 64 ? 63 : c - 1));
  endtask

  task automatic random_phase(int n);
    int r, c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 63);
        c = $urandom_range(0, 63);
      end else begin
        r = $urandom_range(0, cur_rows);
        c = $urandom_range(0, cur_cols);
      end
      send($urandom_range(0, 2) == 0 ? MODE_QUERY : MODE_LOAD, r, c,
           $urandom_range(0, 65535), $urandom_range(0, 4) != 0);
      idle_gap();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: corners, extremes, missing sample, outside grid
    send(MODE_QUERY, 0, 0, 0, 1'b0);
    send(MODE_LOAD, 0, 0, 32767, 1'b1);
    send(MODE_LOAD, 0, 1, -32768, 1'b1);
    send(MODE_LOAD, 1, 0, -1, 1'b1);
    send(MODE_LOAD, 1, 1, 5, 1'b0);
    send(MODE_LOAD, 63, 63, -32768, 1'b1);
    send(MODE_LOAD, 62, 63, 32767, 1'b1);
    send(MODE_QUERY, 0, 0, 0, 1'b0);
    send(MODE_QUERY, 63, 63, 0, 1'b0);
    send(MODE_QUERY, 1, 1, 0, 1'b1);
    configure(3, 5, 8, 0, 0);
    send(MODE_LOAD, 5, 40, 100, 1'b1);
    send(MODE_QUERY, 1, 2, 0, 1'b0);
    send(MODE_QUERY, 2, 4, 0, 1'b0);
    send(MODE_QUERY, 3, 0, 0, 1'b0);
    send(MODE_QUERY, 0, 63, 0, 1'b0);
    configure(64, 64, 1, 63, 1);
    send(MODE_QUERY, 0, 0, 0, 1'b0);
    configure(127, 0, 15, 63, 0);
    send(MODE_QUERY, 0, 0, 0, 1'b0);
    configure(0, 127, 0, 2, 1);
    send(MODE_QUERY, 0, 5, 0, 1'b0);
    // back-pressure: results held while the sender keeps offering
    configure(8, 8, 8, 1, 1);
    long_hold = 1'b1;
    for (int i = 0; i < 6; i++) send(MODE_QUERY, i, 7 - i, 0, 1'b0);
    in_ch.valid <= 1'b0;
    drain();
    random_phase(150);
    configure(16, 12, 5, 2, 0);
    random_phase(100);
    configure(4, 4, 8, 0, 1);
    random_phase(80);
    configure(64, 64, 4, 3, 1);
    random_phase(100);
    in_ch.valid <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("PASS grid_ring_mean_embedding");
    end else begin
      $display("FAIL grid_ring_mean_embedding");
    end
    $finish;
  end
endmodule
